// ===== design/error_diffusion_dither_defines.svh =====
// Assertion macros shared by the dither RTL.
// EDD_ASSERT checks a property on every rising clock edge outside reset.
// EDD_ASSERT_NEVER checks that a condition never holds outside reset.
`ifndef ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_DEFINES_SVH

`ifndef SYNTHESIS

`define EDD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`define EDD_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define EDD_ASSERT(name, clk, rst, prop, msg)

`define EDD_ASSERT_NEVER(name, clk, rst, cond, msg)

`endif

`endif

// ===== design/edd_pkg.sv =====
`timescale 1ns / 1ps

package edd_pkg;

   // Field and register widths
   localparam int PIXEL_W     = 8;
   localparam int ERR_W       = 8;
   localparam int CARRY_W     = 7;
   localparam int IMG_W_BITS  = 11;
   localparam int IMG_H_BITS  = 16;
   localparam int GAIN_W      = 9;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ERROR_GAIN   = 2'd2;

   // Register reset values (gain 155/256 is roughly 0.605)
   localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST  = 11'd1024;
   localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RST = 16'd768;
   localparam logic [GAIN_W-1:0]     ERROR_GAIN_RST   = 9'd155;

   // Gain saturation point (unity in Q1.8)
   localparam logic [GAIN_W-1:0] GAIN_MAX = 9'd256;

   // Output levels and rounding offset for the Q0.8 scale
   localparam logic [PIXEL_W-1:0] LEVEL_HIGH = 8'd255;
   localparam logic [PIXEL_W-1:0] LEVEL_LOW  = 8'd0;
   localparam logic [15:0]        ROUND_HALF = 16'd128;

   // Diffusion weights in sixteenths
   localparam logic [3:0] W_RIGHT       = 4'd7;
   localparam logic [3:0] W_BELOW_LEFT  = 4'd3;
   localparam logic [3:0] W_BELOW       = 4'd5;
   localparam logic [3:0] W_BELOW_RIGHT = 4'd1;

   // Position flags of one pixel in the frame
   typedef struct packed {
      logic first_row;
      logic end_of_row;
      logic end_of_frame;
   } edd_flags_type;

endpackage

// ===== design/error_diffusion_dither.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Ports                        Contents
// req_      in         tvalid tready tdata[7:0]     pixel_value
// rsp_      out        tvalid tready tdata[7:0]     out_level, tlast end_of_row,
//                      tlast tuser                  tuser end_of_frame
// csr_      in         we index[1:0] wdata[15:0]    image_width, image_height, error_gain
//
// One pixel per clock sustained while rsp_tready holds; an accepted request is
// held in the input register alongside the registered read of the row error store,
// then the quantise-and-diffuse pass loads it into the result register.
// Synchronous reset clears position, carried errors and valids; the row error
// store is not cleared, the first row of a frame never uses it.
// A stalled result holds; the input keeps flowing while the result stage is free.
`include "error_diffusion_dither_defines.svh"

module error_diffusion_dither
   import edd_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // [7:0] pixel_value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIXEL_W-1:0]     rsp_tdata,   // [7:0] out_level
   output logic                   rsp_tlast,   // end_of_row
   output logic                   rsp_tuser,   // [0] end_of_frame
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int XW = $clog2(MAX_WIDTH);

   logic [IMG_W_BITS-1:0] image_width;
   logic [IMG_H_BITS-1:0] image_height;
   logic [GAIN_W-1:0]     error_gain;

   logic          accept;
   logic          fire;
   logic [XW-1:0] pos_column;
   edd_flags_type pos_flags;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [XW-1:0]      s1_column_ff;
   edd_flags_type      s1_flags_ff;

   logic signed [ERR_W-1:0] below;
   logic [PIXEL_W-1:0]      level;
   logic                    prim_en;
   logic [XW-1:0]           prim_addr;
   logic signed [ERR_W-1:0] prim_data;
   logic                    defer_en;
   logic [XW-1:0]           defer_addr;
   logic signed [ERR_W-1:0] defer_data;

   logic               out_valid_ff;
   logic               out_valid_in;
   logic [PIXEL_W-1:0] out_level_ff;
   logic               out_eor_ff;
   logic               out_eof_ff;

   edd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .image_width  (image_width),
      .image_height (image_height),
      .error_gain   (error_gain)
   );

   // Handshake: compute when the result register is free or draining
   always_comb begin
      fire         = s1_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready   = !s1_valid_ff || fire;
      accept       = req_tvalid && req_tready;
      s1_valid_in  = accept || (s1_valid_ff && !fire);
      out_valid_in = fire || (out_valid_ff && !rsp_tready);
   end

   edd_position #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .image_width  (image_width),
      .image_height (image_height),
      .column       (pos_column),
      .flags        (pos_flags)
   );

   edd_error_ram #(
      .DEPTH (MAX_WIDTH)
   ) u_error_ram (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (pos_column),
      .rd_data    (below),
      .prim_en    (prim_en),
      .prim_addr  (prim_addr),
      .prim_data  (prim_data),
      .defer_en   (defer_en),
      .defer_addr (defer_addr),
      .defer_data (defer_data)
   );

   // Input register: request and its position
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff  <= req_tdata;
         s1_column_ff <= pos_column;
         s1_flags_ff  <= pos_flags;
      end
   end

   edd_diffuse #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_diffuse (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .pixel      (s1_pixel_ff),
      .column     (s1_column_ff),
      .flags      (s1_flags_ff),
      .below      (below),
      .error_gain (error_gain),
      .level      (level),
      .prim_en    (prim_en),
      .prim_addr  (prim_addr),
      .prim_data  (prim_data),
      .defer_en   (defer_en),
      .defer_addr (defer_addr),
      .defer_data (defer_data)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_level_ff <= level;
         out_eor_ff   <= s1_flags_ff.end_of_row;
         out_eof_ff   <= s1_flags_ff.end_of_frame;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_level_ff;
   assign rsp_tlast  = out_eor_ff;
   assign rsp_tuser  = out_eof_ff;

   `EDD_ASSERT(a_fire_loads_result, clock, reset, (s1_valid_ff && !out_valid_ff) |=> out_valid_ff, "result not loaded")
   `EDD_ASSERT(a_frame_end_row_end, clock, reset, (out_valid_ff && out_eof_ff) |-> out_eor_ff, "frame end off row end")

endmodule

// ===== design/edd_csr.sv =====
`timescale 1ns / 1ps

module edd_csr
   import edd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic [IMG_W_BITS-1:0]  image_width,
   output logic [IMG_H_BITS-1:0]  image_height,
   output logic [GAIN_W-1:0]      error_gain
);

   logic [IMG_W_BITS-1:0] image_width_ff;
   logic [IMG_H_BITS-1:0] image_height_ff;
   logic [GAIN_W-1:0]     error_gain_ff;

   // Take a write into the addressed register; ignore unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
         error_gain_ff   <= ERROR_GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[IMG_W_BITS-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[IMG_H_BITS-1:0];
            end
            REG_ERROR_GAIN: begin
               error_gain_ff <= csr_wdata[GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign image_width  = image_width_ff;
   assign image_height = image_height_ff;
   assign error_gain   = error_gain_ff;

endmodule

// ===== design/edd_position.sv =====
`timescale 1ns / 1ps

module edd_position
   import edd_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [IMG_W_BITS-1:0]        image_width,
   input  logic [IMG_H_BITS-1:0]        image_height,
   output logic [$clog2(MAX_WIDTH)-1:0] column,
   output edd_flags_type                flags
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int MW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (MW > IMG_W_BITS) ? MW : IMG_W_BITS;

   logic [XW-1:0]         col_ff;
   logic [XW-1:0]         col_in;
   logic [IMG_H_BITS-1:0] row_ff;
   logic [IMG_H_BITS-1:0] row_in;

   logic [CW-1:0]         width_ext;
   logic [CW-1:0]         width_eff;
   logic [XW-1:0]         col_last;
   logic [IMG_H_BITS-1:0] row_last;
   logic                  last_col;
   logic                  last_row;

   // Bound the configured size: zero acts as one, width caps at the row store
   always_comb begin
      width_ext = CW'(image_width);
      if (width_ext == '0) begin
         width_eff = CW'(1);
      end else if (width_ext > CW'(MAX_WIDTH)) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      col_last = XW'(width_eff - CW'(1));
      row_last = (image_height == '0) ? '0 : image_height - IMG_H_BITS'(1);
   end

   // A position at or past the last column (row) ends it at once
   always_comb begin
      last_col = (col_ff >= col_last);
      last_row = (row_ff >= row_last);
      column   = last_col ? col_last : col_ff;

      flags.first_row    = (row_ff == '0);
      flags.end_of_row   = last_col;
      flags.end_of_frame = last_col && last_row;

      col_in = last_col ? '0 : column + XW'(1);
      if (last_col) begin
         row_in = last_row ? '0 : row_ff + IMG_H_BITS'(1);
      end else begin
         row_in = row_ff;
      end
   end

   // Advance the raster position on every accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== design/edd_error_ram.sv =====
`timescale 1ns / 1ps
`include "error_diffusion_dither_defines.svh"

module edd_error_ram
   import edd_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic signed [ERR_W-1:0]       rd_data,
   input  logic                          prim_en,
   input  logic [$clog2(DEPTH)-1:0]      prim_addr,
   input  logic signed [ERR_W-1:0]       prim_data,
   input  logic                          defer_en,
   input  logic [$clog2(DEPTH)-1:0]      defer_addr,
   input  logic signed [ERR_W-1:0]       defer_data
);

   localparam int XW = $clog2(DEPTH);

   logic signed [ERR_W-1:0] mem [DEPTH];

   logic signed [ERR_W-1:0] rd_mem_ff;
   logic                    bypass_hit_ff;
   logic                    bypass_hit_in;
   logic signed [ERR_W-1:0] bypass_data_ff;

   logic                    hold_valid_ff;
   logic                    hold_valid_in;
   logic [XW-1:0]           hold_addr_ff;
   logic signed [ERR_W-1:0] hold_data_ff;

   logic                    wr_en;
   logic [XW-1:0]           wr_addr;
   logic signed [ERR_W-1:0] wr_data;

   // Primary write wins the port; a deferred write drains on a free cycle
   always_comb begin
      wr_en         = prim_en || hold_valid_ff;
      wr_addr       = prim_en ? prim_addr : hold_addr_ff;
      wr_data       = prim_en ? prim_data : hold_data_ff;
      hold_valid_in = defer_en || (prim_en && hold_valid_ff);
      bypass_hit_in = wr_en && (wr_addr == rd_addr);
   end

   // Single-port-write row store with a registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_mem_ff      <= mem[rd_addr];
         bypass_data_ff <= wr_data;
      end
   end

   // Forward a write landing on the same edge as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_hit_ff <= 1'b0;
      end else if (rd_en) begin
         bypass_hit_ff <= bypass_hit_in;
      end
   end

   // Hold the second write of a row end
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (defer_en) begin
         hold_addr_ff <= defer_addr;
         hold_data_ff <= defer_data;
      end
   end

   assign rd_data = bypass_hit_ff ? bypass_data_ff : rd_mem_ff;

   `EDD_ASSERT_NEVER(a_defer_overrun, clock, reset, defer_en && hold_valid_ff, "deferred write lost")
   `EDD_ASSERT(a_defer_with_primary, clock, reset, defer_en |-> prim_en, "deferred write alone")
   `EDD_ASSERT(a_hold_drains, clock, reset, (hold_valid_ff && !prim_en) |=> !hold_valid_ff, "hold stuck")

endmodule

// ===== design/edd_diffuse.sv =====
`timescale 1ns / 1ps

module edd_diffuse
   import edd_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [PIXEL_W-1:0]           pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0] column,
   input  edd_flags_type                flags,
   input  logic signed [ERR_W-1:0]      below,
   input  logic [GAIN_W-1:0]            error_gain,
   output logic [PIXEL_W-1:0]           level,
   output logic                         prim_en,
   output logic [$clog2(MAX_WIDTH)-1:0] prim_addr,
   output logic signed [ERR_W-1:0]      prim_data,
   output logic                         defer_en,
   output logic [$clog2(MAX_WIDTH)-1:0] defer_addr,
   output logic signed [ERR_W-1:0]      defer_data
);

   localparam int XW = $clog2(MAX_WIDTH);

   // (mag * num) / 16, truncated
   function automatic logic [6:0] part_mag(input logic [6:0] mag, input logic [3:0] num);
      logic [10:0] prod;
      prod = 11'(mag) * 11'(num);
      return prod[10:4];
   endfunction

   function automatic logic signed [ERR_W-1:0] with_sign(input logic [6:0] mag,
                                                          input logic neg);
      logic signed [ERR_W-1:0] val;
      val = $signed({1'b0, mag});
      return neg ? -val : val;
   endfunction

   logic signed [CARRY_W-1:0] rc_ff;
   logic signed [CARRY_W-1:0] rc_in;
   logic signed [ERR_W-1:0]   pbl_ff;
   logic signed [ERR_W-1:0]   pbl_in;
   logic signed [ERR_W-1:0]   pbh_ff;
   logic signed [ERR_W-1:0]   pbh_in;

   logic signed [ERR_W-1:0] below_use;
   logic signed [9:0]       sum;
   logic [PIXEL_W-1:0]      clamped;
   logic                    high;
   logic [6:0]              err_mag;
   logic [GAIN_W-1:0]       gain_sat;
   logic [15:0]             scaled;
   logic [15:0]             rounded;
   logic [6:0]              e_mag;
   logic signed [ERR_W-1:0] s_right;
   logic signed [ERR_W-1:0] s_below_left;
   logic signed [ERR_W-1:0] s_below;
   logic signed [ERR_W-1:0] s_below_right;
   logic signed [ERR_W-1:0] pbl_next;
   logic                    last_col;

   // Add the waiting errors and clamp to a pixel
   always_comb begin
      below_use = flags.first_row ? '0 : below;
      sum = 10'($signed({1'b0, pixel})) + 10'(rc_ff) + 10'(below_use);
      if (sum[9]) begin
         clamped = '0;
      end else if (sum[8]) begin
         clamped = LEVEL_HIGH;
      end else begin
         clamped = sum[7:0];
      end
      high    = clamped[7];
      level   = high ? LEVEL_HIGH : LEVEL_LOW;
      err_mag = high ? 7'(LEVEL_HIGH - clamped) : clamped[6:0];
   end

   // Scale the error by the gain and round half away from zero
   always_comb begin
      gain_sat = (error_gain > GAIN_MAX) ? GAIN_MAX : error_gain;
      scaled   = 16'(err_mag) * 16'(gain_sat);
      rounded  = scaled + ROUND_HALF;
      e_mag    = rounded[14:8];

      s_right       = with_sign(part_mag(e_mag, W_RIGHT), high);
      s_below_left  = with_sign(part_mag(e_mag, W_BELOW_LEFT), high);
      s_below       = with_sign(part_mag(e_mag, W_BELOW), high);
      s_below_right = with_sign(part_mag(e_mag, W_BELOW_RIGHT), high);
   end

   // Spread the parts; nothing crosses the right edge
   always_comb begin
      last_col = flags.end_of_row;
      pbl_next = pbh_ff + s_below;
      rc_in    = last_col ? '0 : CARRY_W'(s_right);
      pbl_in   = last_col ? '0 : pbl_next;
      pbh_in   = last_col ? '0 : s_below_right;

      if (column != '0) begin
         prim_en   = fire;
         prim_addr = column - XW'(1);
         prim_data = pbl_ff + s_below_left;
      end else begin
         prim_en   = fire && last_col;
         prim_addr = column;
         prim_data = pbl_next;
      end
      defer_en   = fire && last_col && (column != '0);
      defer_addr = column;
      defer_data = pbl_next;
   end

   // Advance the carried errors once per computed pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff  <= '0;
         pbl_ff <= '0;
         pbh_ff <= '0;
      end else if (fire) begin
         rc_ff  <= rc_in;
         pbl_ff <= pbl_in;
         pbh_ff <= pbh_in;
      end
   end

endmodule
